FILE: design/qrs_pkg.sv
package qrs_pkg;
  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS = 35;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LINEAR = 3'd1,
    KIND_DOUBLE = 3'd2,
    KIND_TWO    = 3'd3,
    KIND_ALL    = 3'd4
  } root_kind_e;
endpackage

FILE: design/qrs_sqrt.sv
// Pipelined restoring square root: one result bit per stage.
module qrs_sqrt #(
  parameter int IN_BITS  = 64,
  parameter int TAG_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [IN_BITS-1:0]    rad_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  output logic                  valid_o,
  output logic [IN_BITS/2-1:0]  root_o,
  output logic [TAG_BITS-1:0]   tag_o
);
  localparam int RB = IN_BITS / 2;

  logic [RB:0]           vld_q;
  logic [IN_BITS-1:0]    rad_q  [RB+1];
  logic [RB+1:0]         rem_q  [RB+1];
  logic [RB-1:0]         rt_q   [RB+1];
  logic [TAG_BITS-1:0]   tag_q  [RB+1];

  always_comb begin
    rad_q[0] = rad_i;
    rem_q[0] = '0;
    rt_q[0]  = '0;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < RB; s++) begin : g_st
    logic [RB+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {rem_q[s][RB-1:0], rad_q[s][IN_BITS-1 -: 2]};
      trial  = {rt_q[s], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1] <= rad_q[s] << 2;
      tag_q[s+1] <= tag_q[s];
      if (rem_sh >= trial) begin
        rem_q[s+1] <= rem_sh - trial;
        rt_q[s+1]  <= {rt_q[s][RB-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= rem_sh;
        rt_q[s+1]  <= {rt_q[s][RB-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[RB];
  assign root_o  = rt_q[RB];
  assign tag_o   = tag_q[RB];
endmodule

FILE: design/qrs_div.sv
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
module qrs_div #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 34,
  parameter int TAG_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [NUM_BITS-1:0]  num_i,
  input  logic signed [DEN_BITS-1:0]  den_i,
  input  logic [TAG_BITS-1:0]         tag_i,
  output logic                        valid_o,
  output logic signed [NUM_BITS:0]    quo_o,
  output logic [TAG_BITS-1:0]         tag_o
);
  localparam int N = NUM_BITS;

  logic [N:0]          vld_q;
  logic [N-1:0]        nm_q  [N+1];
  logic [DEN_BITS:0]   dm_q  [N+1];
  logic [DEN_BITS:0]   rem_q [N+1];
  logic [N-1:0]        qt_q  [N+1];
  logic                neg_q [N+1];
  logic [TAG_BITS-1:0] tag_q [N+1];

  always_comb begin
    vld_q[0] = valid_i;
    nm_q[0]  = num_i[N-1] ? N'(-num_i) : N'(num_i);
    dm_q[0]  = den_i[DEN_BITS-1] ? (DEN_BITS+1)'(-{den_i[DEN_BITS-1], den_i})
                                 : (DEN_BITS+1)'({den_i[DEN_BITS-1], den_i});
    rem_q[0] = '0;
    qt_q[0]  = '0;
    neg_q[0] = num_i[N-1] ^ den_i[DEN_BITS-1];
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [DEN_BITS+1:0] rs;
    always_comb rs = {rem_q[s], nm_q[s][N-1]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      nm_q[s+1]  <= nm_q[s] << 1;
      dm_q[s+1]  <= dm_q[s];
      neg_q[s+1] <= neg_q[s];
      tag_q[s+1] <= tag_q[s];
      if (rs >= {1'b0, dm_q[s]}) begin
        rem_q[s+1] <= (DEN_BITS+1)'(rs - {1'b0, dm_q[s]});
        qt_q[s+1]  <= {qt_q[s][N-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= rs[DEN_BITS:0];
        qt_q[s+1]  <= {qt_q[s][N-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = neg_q[N] ? -$signed({1'b0, qt_q[N]}) : $signed({1'b0, qt_q[N]});
  assign tag_o   = tag_q[N];
endmodule

FILE: design/quadratic_root_solver.sv
// Quadratic root solver: classifies and solves a*x^2 + b*x + c = 0.
// Input: start_i with coef_a_i, coef_b_i, coef_c_i; a word is taken at each edge
// where start_i is high and busy_o low. busy_o is always low: one word per cycle.
// Output: done_o is high for one cycle with root_kind_o, root_one_o, root_two_o.
// The pipeline has 3 front stages (products, discriminant, scaling), then
// COEF_BITS+FRAC_BITS+1 square root stages, one numerator stage, then
// COEF_BITS+FRAC_BITS+3 divider stages and one saturating output register. The
// square root and divider pipelines are bit-serial, one bit per stage.
// Roots are fixed point with FRAC_BITS fraction bits, truncated toward zero and
// saturated to 35 bits. Absent roots read as zero.
// Reset empties the pipeline; no result appears until a word has gone through.
// The receiver cannot stall, so results leave in input order, one per cycle.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [15:0]  coef_a_i,
  input  logic signed [15:0]  coef_b_i,
  input  logic signed [15:0]  coef_c_i,
  output logic                done_o,
  output logic [2:0]          root_kind_o,
  output logic signed [34:0]  root_one_o,
  output logic signed [34:0]  root_two_o
);
  localparam int CB  = COEF_BITS;
  localparam int DB  = 2 * CB + 2;          // discriminant width, unsigned
  localparam int RAD = 2 * (CB + 1 + FRAC_BITS);  // even radicand width
  localparam int SQB = RAD / 2;
  localparam int NB  = CB + 2 + FRAC_BITS + 1;    // numerator width, signed
  localparam int DNB = CB + 2;                    // denominator width
  localparam int TW  = 3 + NB + NB + DNB;

  assign busy_o = 1'b0;

  logic signed [CB-1:0] a_w, b_w, c_w;
  assign a_w = coef_a_i[CB-1:0];
  assign b_w = coef_b_i[CB-1:0];
  assign c_w = coef_c_i[CB-1:0];

  // stage 1: products
  logic                     v1_q;
  logic signed [CB-1:0]     a1_q, b1_q, c1_q;
  logic [2*CB-1:0]          bb1_q;
  logic signed [2*CB+1:0]   ac4_1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    a1_q    <= a_w;
    b1_q    <= b_w;
    c1_q    <= c_w;
    bb1_q   <= (2*CB)'(b_w * b_w);
    ac4_1_q <= (2*CB+2)'(a_w * c_w) <<< 2;
  end

  // stage 2: discriminant and kind
  logic                      v2_q;
  logic [2:0]                k2_q;
  logic [DB-1:0]             d2_q;
  logic signed [CB-1:0]      a2_q, b2_q, c2_q;
  logic signed [DB:0]        dl;
  logic [2:0]                k2_d;
  assign dl = $signed({2'b00, bb1_q}) - $signed({ac4_1_q[2*CB+1], ac4_1_q});
  always_comb begin
    priority if (a1_q == '0) begin
      if (b1_q != '0)      k2_d = KIND_LINEAR;
      else if (c1_q == '0) k2_d = KIND_ALL;
      else                 k2_d = KIND_NONE;
    end else if (dl < 0) k2_d = KIND_NONE;
    else if (dl == 0)    k2_d = KIND_DOUBLE;
    else                 k2_d = KIND_TWO;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    k2_q <= k2_d;
    d2_q <= (k2_d == KIND_TWO) ? dl[DB-1:0] : '0;
    a2_q <= a1_q;
    b2_q <= b1_q;
    c2_q <= c1_q;
  end

  // stage 3: radicand, numerator base and denominator
  logic                     v3_q;
  logic [RAD-1:0]           rad3_q;
  logic [TW-1:0]            tag3_q;
  logic signed [NB-1:0]     nb_d;
  logic signed [DNB-1:0]    den_d;
  always_comb begin
    if (a2_q == '0) begin
      nb_d  = -($signed({{(NB-CB){c2_q[CB-1]}}, c2_q}) <<< FRAC_BITS);
      den_d = DNB'(b2_q);
    end else begin
      nb_d  = -($signed({{(NB-CB){b2_q[CB-1]}}, b2_q}) <<< FRAC_BITS);
      den_d = DNB'(a2_q) <<< 1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    rad3_q <= RAD'(d2_q) << (2 * FRAC_BITS);
    tag3_q <= {k2_q, nb_d, nb_d, den_d};
  end

  logic            vs;
  logic [SQB-1:0]  sq;
  logic [TW-1:0]   tags;
  qrs_sqrt #(.IN_BITS(RAD), .TAG_BITS(TW)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(v3_q), .rad_i(rad3_q), .tag_i(tag3_q),
    .valid_o(vs), .root_o(sq), .tag_o(tags)
  );

  // numerators after the root
  logic                  v4_q;
  logic signed [NB-1:0]  n1_q, n2_q;
  logic signed [DNB-1:0] dn4_q;
  logic [2:0]            k4_q;
  logic signed [NB-1:0]  nbs;
  assign nbs = tags[DNB+:NB];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= vs;
  end
  always_ff @(posedge clk_i) begin
    k4_q  <= tags[TW-1 -: 3];
    dn4_q <= tags[DNB-1:0];
    n1_q  <= nbs + $signed(NB'(sq));
    n2_q  <= nbs - $signed(NB'(sq));
  end

  // two dividers side by side
  localparam int T2 = 3 + 1;
  logic                v5a, v5b;
  logic signed [NB:0]  q1, q2;
  logic [T2-1:0]       t5a, t5b;
  logic [T2-1:0]       tag4;
  assign tag4 = {k4_q, 1'b0};
  qrs_div #(.NUM_BITS(NB), .DEN_BITS(DNB), .TAG_BITS(T2)) u_div1 (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i(n1_q), .den_i(dn4_q), .tag_i(tag4),
    .valid_o(v5a), .quo_o(q1), .tag_o(t5a)
  );
  qrs_div #(.NUM_BITS(NB), .DEN_BITS(DNB), .TAG_BITS(T2)) u_div2 (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i(n2_q), .den_i(dn4_q), .tag_i(tag4),
    .valid_o(v5b), .quo_o(q2), .tag_o(t5b)
  );

  function automatic logic signed [34:0] sat(input logic signed [NB:0] v);
    logic signed [NB+35:0] x;
    x = (NB+36)'(v);
    if (x > (NB+36)'(35'sh3_FFFF_FFFF))      sat = 35'sh3_FFFF_FFFF;
    else if (x < -(NB+36)'(36'sh4_0000_0000)) sat = 35'sh4_0000_0000;
    else                                     sat = x[34:0];
  endfunction

  logic [2:0] k5;
  assign k5 = t5a[T2-1:1];

  logic done_q;
  logic [2:0] kind_q;
  logic signed [34:0] r1_q, r2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= v5a & v5b & ~t5a[0] & ~t5b[0];
  end
  always_ff @(posedge clk_i) begin
    kind_q <= k5;
    unique case (k5)
      KIND_LINEAR: begin r1_q <= sat(q1); r2_q <= '0; end
      KIND_DOUBLE, KIND_TWO: begin r1_q <= sat(q1); r2_q <= sat(q2); end
      default: begin r1_q <= '0; r2_q <= '0; end
    endcase
  end

  assign done_o      = done_q;
  assign root_kind_o = kind_q;
  assign root_one_o  = r1_q;
  assign root_two_o  = r2_q;
endmodule

FILE: design/qrs_checker.sv
module qrs_checker
  import qrs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy_o,
  input logic               done_o,
  input logic [2:0]         root_kind_o,
  input logic signed [34:0] root_one_o,
  input logic signed [34:0] root_two_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> root_kind_o <= 3'd4) else $error("bad kind");
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (root_kind_o == KIND_NONE || root_kind_o == KIND_ALL)
    |-> root_one_o == '0 && root_two_o == '0) else $error("absent root not zero");
  a_double_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && root_kind_o == KIND_DOUBLE |-> root_one_o == root_two_o)
    else $error("double root differs");
  a_linear_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && root_kind_o == KIND_LINEAR |-> root_two_o == '0)
    else $error("linear second root");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

FILE: test/quadratic_root_solver_tb.sv
module quadratic_root_solver_tb;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LATENCY  = 73;
  localparam longint ROOT_MAX = (64'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam longint ROOT_MIN = -(64'sd1 <<< (OUT_BITS - 1));

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } coef_word_t;

  typedef struct packed {
    root_kind_e         kind;
    logic signed [34:0] one;
    logic signed [34:0] two;
  } root_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [15:0] coef_a_i;
  logic signed [15:0] coef_b_i;
  logic signed [15:0] coef_c_i;
  logic               done_o;
  logic [2:0]         root_kind_o;
  logic signed [34:0] root_one_o;
  logic signed [34:0] root_two_o;

  coef_word_t coef_pending[$];
  root_word_t roots_due[$];
  int         idle_pct;
  int         taken;
  bit         failed;

  quadratic_root_solver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .coef_a_i   (coef_a_i),
    .coef_b_i   (coef_b_i),
    .coef_c_i   (coef_c_i),
    .done_o     (done_o),
    .root_kind_o(root_kind_o),
    .root_one_o (root_one_o),
    .root_two_o (root_two_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [34:0] clamp_root(longint v);
    if (v > ROOT_MAX) v = ROOT_MAX;
    if (v < ROOT_MIN) v = ROOT_MIN;
    return v[34:0];
  endfunction

  function automatic root_word_t solve_roots(coef_word_t w);
    longint      sa, sb, sc, nb, den, delta, r1, r2;
    logic [127:0] scaled, sq, cand;
    root_word_t  r;
    sa = w.a;
    sb = w.b;
    sc = w.c;
    r1 = 0;
    r2 = 0;
    r.kind = KIND_NONE;
    if (sa == 0) begin
      if (sb != 0) begin
        r.kind = KIND_LINEAR;
        r1 = (-sc * (64'sd1 <<< FRAC_BITS_DEF)) / sb;
      end else begin
        r.kind = (sc == 0) ? KIND_ALL : KIND_NONE;
      end
    end else begin
      nb = -sb * (64'sd1 <<< FRAC_BITS_DEF);
      den = 2 * sa;
      delta = sb * sb - 4 * sa * sc;
      if (delta == 0) begin
        r.kind = KIND_DOUBLE;
        r1 = nb / den;
        r2 = r1;
      end else if (delta > 0) begin
        r.kind = KIND_TWO;
        scaled = 128'(delta) << (2 * FRAC_BITS_DEF);
        sq = '0;
        for (int i = 48; i >= 0; i--) begin
          cand = sq | (128'd1 << i);
          if (cand * cand <= scaled) sq = cand;
        end
        r1 = (nb + longint'(sq[63:0])) / den;
        r2 = (nb - longint'(sq[63:0])) / den;
      end
    end
    r.one = clamp_root(r1);
    r.two = clamp_root(r2);
    return r;
  endfunction

  function automatic coef_word_t coef(int a, int b, int c);
    coef_word_t w;
    w.a = a[15:0];
    w.b = b[15:0];
    w.c = c[15:0];
    return w;
  endfunction

  // driver: present the next word at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni || coef_pending.size() == 0 || $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
    end else begin
      start_i  <= 1'b1;
      coef_a_i <= coef_pending[0].a;
      coef_b_i <= coef_pending[0].b;
      coef_c_i <= coef_pending[0].c;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      roots_due.push_back(solve_roots(coef_pending.pop_front()));
      taken++;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    root_word_t e;
    if (rst_ni && done_o) begin
      if (roots_due.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = roots_due.pop_front();
        if (root_kind_o !== e.kind) begin
          $error("root_kind: expected %0d, got %0d", e.kind, root_kind_o);
          failed = 1'b1;
        end
        if (root_one_o !== e.one) begin
          $error("root_one: expected %0d, got %0d", e.one, root_one_o);
          failed = 1'b1;
        end
        if (root_two_o !== e.two) begin
          $error("root_two: expected %0d, got %0d", e.two, root_two_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int a, b, c, k;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    coef_a_i = '0;
    coef_b_i = '0;
    coef_c_i = '0;
    idle_pct = 0;
    taken    = 0;
    failed   = 1'b0;
    // directed: all reals, no root, linear, double, two roots, negative discriminant
    coef_pending.push_back(coef(0, 0, 0));
    coef_pending.push_back(coef(0, 0, 5));
    coef_pending.push_back(coef(0, 0, -32768));
    coef_pending.push_back(coef(0, 3, 7));
    coef_pending.push_back(coef(0, 1, -32768));
    coef_pending.push_back(coef(0, -32768, 32767));
    coef_pending.push_back(coef(0, -1, -32768));
    coef_pending.push_back(coef(1, 2, 1));
    coef_pending.push_back(coef(-3, 12, -12));
    coef_pending.push_back(coef(1, 0, 1));
    coef_pending.push_back(coef(1, -3, 2));
    coef_pending.push_back(coef(1, 0, 0));
    coef_pending.push_back(coef(32767, 32767, 32767));
    coef_pending.push_back(coef(-32768, -32768, -32768));
    coef_pending.push_back(coef(-32768, 0, 32767));
    coef_pending.push_back(coef(32767, -32768, -32768));
    coef_pending.push_back(coef(1, -32768, -32768));
    coef_pending.push_back(coef(1, 32767, 0));
    coef_pending.push_back(coef(-1, -32768, 32767));
    coef_pending.push_back(coef(32767, 1, -1));
    for (int n = 0; n < 850; n++) begin
      a = $signed(16'($urandom));
      b = $signed(16'($urandom));
      c = $signed(16'($urandom));
      case ($urandom_range(9))
        0: a = 0;
        1: begin a = 0; b = $urandom_range(0, 1) ? 0 : b; end
        2: c = 0;
        3: begin // perfect square: double root
          a = $urandom_range(1, 20) * ($urandom_range(1) ? 1 : -1);
          k = $urandom_range(0, 40) - 20;
          b = 2 * a * k;
          c = a * k * k;
        end
        4: begin
          a = $urandom_range(0, 31) - 16;
          b = $urandom_range(0, 63) - 32;
          c = $urandom_range(0, 31) - 16;
        end
        default: ;
      endcase
      coef_pending.push_back(coef(a, b, c));
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (taken >= 200);
    idle_pct = 75;
    wait (taken >= 450);
    idle_pct = 0;
    wait (taken >= 650);
    idle_pct = 15;
    wait (coef_pending.size() == 0 && roots_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed && roots_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
